### rtl/qat_pkg.sv
// Shared types, character codes and helper functions for the quoted argument tokenizer.
package qat_pkg;

	// Parse modes of the tokenizer
	typedef enum logic [2:0] {
		MODE_BETWEEN  = 3'd0,
		MODE_SQUOTE   = 3'd1,
		MODE_DQUOTE   = 3'd2,
		MODE_DQ_ESC   = 3'd3,
		MODE_WORD     = 3'd4,
		MODE_WORD_ESC = 3'd5
	} mode_t;

	// Result kinds on the output channel
	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_CMD_END   = 2'd2
	} kind_t;

	// Character codes
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// One queued transaction: first result, plus an optional trailing command end
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       two;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		if (c == CH_N) begin
			unescape = CH_LF;
		end else if (c == CH_R) begin
			unescape = CH_CR;
		end else if (c == CH_T) begin
			unescape = CH_TAB;
		end else begin
			unescape = c;
		end
	endfunction

endpackage

### rtl/quoted_argument_tokenizer.sv
// Quoted argument tokenizer: the top level joining front end, result queue and back end.
// Takes one command byte per cycle while the queue has room and emits a stream of token
// characters, token-end marks and command-end marks. The front end's parse state updates
// in the cycle that accepts a byte, so bytes may arrive back to back. Most bytes cause zero
// or one result; an end of command that closes a non-empty token causes two, and those pass
// one at a time through the single-result output register. A four-entry queue between the
// parser and the output register absorbs such bursts and output stalls; input ready drops
// only while that queue is full. Results pass through the queue, then the output register.
module quoted_argument_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_command,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] result_kind,
	output logic       last_of_item
);

	qat_pkg::push_t  push;
	qat_pkg::entry_t q_entry;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;

	qat_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.end_of_command (end_of_command),
		.q_full         (q_full),
		.push           (push)
	);

	qat_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_entry)
	);

	qat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.result_kind  (result_kind),
		.last_of_item (last_of_item)
	);

endmodule

### rtl/qat_front.sv
// Front end: accepts input bytes, runs the parse state machine and queues results.
module qat_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           end_of_command,
	input  logic           q_full,
	output qat_pkg::push_t push
);

	qat_pkg::mode_t mode_q, mode_d;
	logic           has_q, has_d;
	logic           accept;
	logic           emit_char, emit_tend, emit_cend;
	logic [7:0]     ch;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Decode which results this byte causes
	always_comb begin
		emit_char = 1'b0;
		emit_tend = 1'b0;
		emit_cend = 1'b0;
		ch        = in_byte;
		if (end_of_command) begin
			emit_tend = has_q;
			emit_cend = 1'b1;
		end else begin
			case (mode_q)
				qat_pkg::MODE_SQUOTE: begin
					emit_char = (in_byte != qat_pkg::CH_SQUOTE);
				end
				qat_pkg::MODE_DQUOTE: begin
					emit_char = (in_byte != qat_pkg::CH_BSLASH) &&
					            (in_byte != qat_pkg::CH_DQUOTE);
				end
				qat_pkg::MODE_DQ_ESC, qat_pkg::MODE_WORD_ESC: begin
					ch        = qat_pkg::unescape(in_byte);
					emit_char = 1'b1;
				end
				qat_pkg::MODE_WORD: begin
					if ((in_byte == qat_pkg::CH_BSLASH) || (in_byte == qat_pkg::CH_SQUOTE) ||
					    (in_byte == qat_pkg::CH_DQUOTE)) begin
						emit_char = 1'b0;
					end else if (qat_pkg::is_blank(in_byte)) begin
						emit_tend = 1'b1;
					end else begin
						emit_char = 1'b1;
					end
				end
				default: begin
					emit_char = (in_byte != qat_pkg::CH_SQUOTE) &&
					            (in_byte != qat_pkg::CH_DQUOTE) &&
					            !qat_pkg::is_blank(in_byte);
				end
			endcase
		end
	end

	// Form the queue entry
	always_comb begin
		push.valid      = accept && (emit_char || emit_tend || emit_cend);
		push.entry.two  = emit_tend && emit_cend;
		push.entry.data = emit_char ? ch : 8'h00;
		if (emit_char) begin
			push.entry.kind = qat_pkg::KIND_CHAR;
		end else if (emit_tend) begin
			push.entry.kind = qat_pkg::KIND_TOKEN_END;
		end else begin
			push.entry.kind = qat_pkg::KIND_CMD_END;
		end
	end

	// Next parse mode and token fill flag
	always_comb begin
		mode_d = mode_q;
		if (end_of_command) begin
			mode_d = qat_pkg::MODE_BETWEEN;
		end else begin
			case (mode_q)
				qat_pkg::MODE_SQUOTE: begin
					if (in_byte == qat_pkg::CH_SQUOTE) mode_d = qat_pkg::MODE_WORD;
				end
				qat_pkg::MODE_DQUOTE: begin
					if (in_byte == qat_pkg::CH_BSLASH) begin
						mode_d = qat_pkg::MODE_DQ_ESC;
					end else if (in_byte == qat_pkg::CH_DQUOTE) begin
						mode_d = qat_pkg::MODE_WORD;
					end
				end
				qat_pkg::MODE_DQ_ESC: begin
					mode_d = qat_pkg::MODE_DQUOTE;
				end
				qat_pkg::MODE_WORD: begin
					if (in_byte == qat_pkg::CH_BSLASH) begin
						mode_d = qat_pkg::MODE_WORD_ESC;
					end else if (in_byte == qat_pkg::CH_SQUOTE) begin
						mode_d = qat_pkg::MODE_SQUOTE;
					end else if (in_byte == qat_pkg::CH_DQUOTE) begin
						mode_d = qat_pkg::MODE_DQUOTE;
					end else if (qat_pkg::is_blank(in_byte)) begin
						mode_d = qat_pkg::MODE_BETWEEN;
					end
				end
				qat_pkg::MODE_WORD_ESC: begin
					mode_d = qat_pkg::MODE_WORD;
				end
				default: begin
					if (in_byte == qat_pkg::CH_SQUOTE) begin
						mode_d = qat_pkg::MODE_SQUOTE;
					end else if (in_byte == qat_pkg::CH_DQUOTE) begin
						mode_d = qat_pkg::MODE_DQUOTE;
					end else if (qat_pkg::is_blank(in_byte)) begin
						mode_d = qat_pkg::MODE_BETWEEN;
					end else begin
						mode_d = qat_pkg::MODE_WORD;
					end
				end
			endcase
		end
		if (end_of_command || emit_tend) begin
			has_d = 1'b0;
		end else if (emit_char) begin
			has_d = 1'b1;
		end else begin
			has_d = has_q;
		end
	end

	// Advance state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qat_pkg::MODE_BETWEEN;
			has_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			has_q  <= has_d;
		end
	end

	// End of command always leaves a clean parser
	a_eoc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_command |=> (mode_q == qat_pkg::MODE_BETWEEN) && !has_q)
		else $error("parser not cleared after end of command");

	// A paired entry is always token end followed by command end
	a_two_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.entry.two |-> push.entry.kind == qat_pkg::KIND_TOKEN_END)
		else $error("paired entry with wrong first kind");

	// Every end of command queues something
	a_eoc_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_command |-> push.valid)
		else $error("end of command dropped");

endmodule

### rtl/qat_queue.sv
// Short queue of pending result entries between the front and back ends.
module qat_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  qat_pkg::push_t  push,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output qat_pkg::entry_t rd_entry
);

	qat_pkg::entry_t              mem_q [qat_pkg::QDEPTH];
	logic [qat_pkg::QAW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [qat_pkg::QCW-1:0]      count_q;
	logic                         do_pop;

	assign full     = (count_q == qat_pkg::QCW'(qat_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push.valid && !full) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if ((push.valid && !full) && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!(push.valid && !full) && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full))
		else $error("push into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qat_pkg::QCW'(qat_pkg::QDEPTH))
		else $error("queue occupancy out of range");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != qat_pkg::QCW'(qat_pkg::QDEPTH)) |->
		(qat_pkg::QAW'(wr_ptr_q - rd_ptr_q) == count_q[qat_pkg::QAW-1:0]))
		else $error("queue pointers disagree with occupancy");

endmodule

### rtl/qat_back.sv
// Back end: unpacks queued entries into result transactions through an output register.
module qat_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  qat_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      result_kind,
	output logic            last_of_item
);

	logic           out_valid_q;
	logic [7:0]     byte_q;
	qat_pkg::kind_t kind_q;
	logic           last_q;
	logic           phase_q;
	logic           load;
	logic           first_half;

	assign load       = q_valid && (!out_valid_q || out_ready);
	assign first_half = q_entry.two && !phase_q;
	assign q_pop      = load && !first_half;

	// Control: valid flag and phase of a paired entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= first_half;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold until taken, then load the next result
	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				byte_q <= 8'h00;
				kind_q <= qat_pkg::KIND_CMD_END;
			end else begin
				byte_q <= q_entry.data;
				kind_q <= q_entry.kind;
			end
			last_q <= !first_half;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = byte_q;
	assign result_kind  = kind_q;
	assign last_of_item = last_q;

	// Second half pending means the first half sits in the output register
	a_phase_out: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> out_valid_q && !last_q && (kind_q == qat_pkg::KIND_TOKEN_END))
		else $error("paired entry out of step");

	// A command end is always the last result of its transaction
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == qat_pkg::KIND_CMD_END) |-> last_q)
		else $error("command end not marked last");

	// Non-character results carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q != qat_pkg::KIND_CHAR) |-> byte_q == 8'h00)
		else $error("nonzero byte on mark result");

endmodule

### dv/testbench.sv
// Self-checking testbench for the quoted argument tokenizer.
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic [7:0]     data;
		qat_pkg::kind_t kind;
		logic           last;
	} tok_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       end_of_command;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] result_kind;
	logic       last_of_item;

	// Parser state mirrored by the predictor
	qat_pkg::mode_t tok_mode = qat_pkg::MODE_BETWEEN;
	logic           token_open = 1'b0;

	tok_result_t pending_results[$];
	int          mismatches = 0;
	bit          calm = 1'b0;
	int          hold_left = 0;

	quoted_argument_tokenizer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.end_of_command (end_of_command),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.result_kind    (result_kind),
		.last_of_item   (last_of_item)
	);

	always #6 clk = ~clk;

	function automatic logic is_separator(input logic [7:0] c);
		return c == qat_pkg::CH_SPACE || c == qat_pkg::CH_TAB ||
		       c == qat_pkg::CH_LF || c == qat_pkg::CH_CR;
	endfunction

	function automatic logic [7:0] escaped_char(input logic [7:0] c);
		case (c)
			qat_pkg::CH_N: return qat_pkg::CH_LF;
			qat_pkg::CH_R: return qat_pkg::CH_CR;
			qat_pkg::CH_T: return qat_pkg::CH_TAB;
			default: return c;
		endcase
	endfunction

	function automatic void add_result(input logic [7:0] data, input qat_pkg::kind_t kind);
		tok_result_t r;
		r.data = data;
		r.kind = kind;
		r.last = 1'b0;
		pending_results.push_back(r);
	endfunction

	// Advance the mirrored parser by one byte and queue the results it causes
	task automatic predict_tokens(input logic [7:0] b, input logic eoc);
		int         n;
		logic       emit;
		logic [7:0] ch;
		n = 0;
		emit = 1'b0;
		ch = b;
		if (eoc) begin
			if (token_open) begin
				add_result(8'h00, qat_pkg::KIND_TOKEN_END);
				n++;
			end
			add_result(8'h00, qat_pkg::KIND_CMD_END);
			n++;
			tok_mode = qat_pkg::MODE_BETWEEN;
			token_open = 1'b0;
		end else begin
			case (tok_mode)
				qat_pkg::MODE_SQUOTE: begin
					if (b == qat_pkg::CH_SQUOTE) tok_mode = qat_pkg::MODE_WORD;
					else emit = 1'b1;
				end
				qat_pkg::MODE_DQUOTE: begin
					if (b == qat_pkg::CH_BSLASH) tok_mode = qat_pkg::MODE_DQ_ESC;
					else if (b == qat_pkg::CH_DQUOTE) tok_mode = qat_pkg::MODE_WORD;
					else emit = 1'b1;
				end
				qat_pkg::MODE_DQ_ESC: begin
					ch = escaped_char(b);
					emit = 1'b1;
					tok_mode = qat_pkg::MODE_DQUOTE;
				end
				qat_pkg::MODE_WORD: begin
					if (b == qat_pkg::CH_BSLASH) tok_mode = qat_pkg::MODE_WORD_ESC;
					else if (b == qat_pkg::CH_SQUOTE) tok_mode = qat_pkg::MODE_SQUOTE;
					else if (b == qat_pkg::CH_DQUOTE) tok_mode = qat_pkg::MODE_DQUOTE;
					else if (is_separator(b)) begin
						add_result(8'h00, qat_pkg::KIND_TOKEN_END);
						n++;
						token_open = 1'b0;
						tok_mode = qat_pkg::MODE_BETWEEN;
					end else emit = 1'b1;
				end
				qat_pkg::MODE_WORD_ESC: begin
					ch = escaped_char(b);
					emit = 1'b1;
					tok_mode = qat_pkg::MODE_WORD;
				end
				default: begin
					if (b == qat_pkg::CH_SQUOTE) tok_mode = qat_pkg::MODE_SQUOTE;
					else if (b == qat_pkg::CH_DQUOTE) tok_mode = qat_pkg::MODE_DQUOTE;
					else if (is_separator(b)) tok_mode = qat_pkg::MODE_BETWEEN;
					else begin
						emit = 1'b1;
						tok_mode = qat_pkg::MODE_WORD;
					end
				end
			endcase
			if (emit) begin
				add_result(ch, qat_pkg::KIND_CHAR);
				n++;
				token_open = 1'b1;
			end
		end
		// Flag the final result of this transaction
		if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
	endtask

	// Offer one byte, hold it until accepted; entered and left at a falling edge
	task automatic send_item(input logic [7:0] b, input logic eoc);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_command <= eoc;
		do @(posedge clk); while (!in_ready);
		predict_tokens(b, eoc);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	// Drop valid and wait until every expected result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Pick a byte biased toward the characters the parser reacts to
	function automatic logic [7:0] shell_byte();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return 8'($urandom_range(8'h61, 8'h7a));
		if (roll < 45) begin
			case ($urandom_range(0, 2))
				0: return qat_pkg::CH_N;
				1: return qat_pkg::CH_R;
				default: return qat_pkg::CH_T;
			endcase
		end
		if (roll < 55) return qat_pkg::CH_BSLASH;
		if (roll < 63) return qat_pkg::CH_SQUOTE;
		if (roll < 71) return qat_pkg::CH_DQUOTE;
		if (roll < 86) begin
			case ($urandom_range(0, 3))
				0: return qat_pkg::CH_SPACE;
				1: return qat_pkg::CH_TAB;
				2: return qat_pkg::CH_LF;
				default: return qat_pkg::CH_CR;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_special_cases();
		// zero and all-ones bytes are ordinary characters; tab closes the word
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hff, 1'b0);
		send_item(qat_pkg::CH_TAB, 1'b0);
		// empty quoted token still closes on a blank
		send_text("''");
		send_item(qat_pkg::CH_SPACE, 1'b0);
		// escapes inside double quotes and in a bare word
		send_text("\"\\n\\r\\q\"\\t");
		send_item(qat_pkg::CH_CR, 1'b0);
		send_item(qat_pkg::CH_LF, 1'b0);
		// end of command inside an unclosed quote, byte ignored
		send_text("'x");
		send_item(8'hff, 1'b1);
		// end of command with nothing pending
		send_item(8'h00, 1'b1);
		// dangling escape dropped at end of command
		send_text("b\\");
		send_item(8'h5a, 1'b1);
		drain_results();
	endtask

	task automatic test_output_stall();
		int i;
		hold_left = 80;
		calm = 1'b1;
		for (i = 0; i < 40; i++) send_item(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
		send_item(8'h00, 1'b1);
		calm = 1'b0;
		drain_results();
	endtask

	task automatic test_commands(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 18);
			repeat (len) begin
				send_item(shell_byte(), 1'b0);
				sent++;
			end
			send_item(8'($urandom_range(0, 255)), 1'b1);
			sent++;
		end
	endtask

	task automatic test_raw_bytes(input int n_items);
		repeat (n_items) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Receiver: random stalls, plus a long hold-off when requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= calm || $urandom_range(0, 99) >= 17;
			end
		end
	end

	// Compare each transaction out with the oldest expectation
	always @(posedge clk) begin : check_results
		tok_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got byte %02h kind %0d last %0b",
					$time, out_byte, result_kind, last_of_item);
			end else begin
				want = pending_results.pop_front();
				if (out_byte !== want.data) begin
					mismatches++;
					$display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte);
				end
				if (result_kind !== want.kind) begin
					mismatches++;
					$display("%0t: result_kind expected %0d, got %0d", $time, want.kind,
						result_kind);
				end
				if (last_of_item !== want.last) begin
					mismatches++;
					$display("%0t: last_of_item expected %0b, got %0b", $time, want.last,
						last_of_item);
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_command = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_special_cases();
		test_output_stall();
		calm = 1'b1;
		test_commands(220);
		calm = 1'b0;
		test_commands(660);
		test_raw_bytes(200);
		drain_results();

		// Let any stray result show up before the verdict
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/qat_pkg.sv
rtl/qat_front.sv
rtl/qat_queue.sv
rtl/qat_back.sv
rtl/quoted_argument_tokenizer.sv
dv/testbench.sv
